### rtl/pcb_pkg.sv
// Shared types and constants for the particle cell list binning block.
`default_nettype none

package pcb_pkg;

	localparam int GRID_DIM_DEF = 16;
	localparam int MAX_PART_DEF = 4096;

	localparam int ID_W   = 12;
	localparam int POS_W  = 32;
	localparam int CELL_W = 12;
	localparam int DATA_W = 32;

	localparam logic [POS_W-1:0] CELL_SIZE_RST = 32'd268435456;

	localparam int FIFO_DEPTH = 2;

	localparam int APB_ADDR_W = 2;
	localparam logic [APB_ADDR_W-1:0] ADDR_CELL_SIZE = 2'd0;

	typedef struct packed {
		logic [ID_W-1:0]  particle_id;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [POS_W-1:0] pos_z;
	} in_item_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_index;
		logic              was_empty;
		logic [ID_W-1:0]   linked_after;
	} out_item_t;

endpackage

`default_nettype wire

### rtl/pcb_fifo.sv
// Small synchronous queue used between the stages and at the result side.
`default_nettype none

module pcb_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = pcb_pkg::FIFO_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] din,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] dout,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

endmodule

`default_nettype wire

### rtl/pcb_front.sv
// Front end: takes an item, divides the three coordinates by the cell size, forms the cell.
`default_nettype none

module pcb_front #(
	parameter int GRID_DIM = pcb_pkg::GRID_DIM_DEF,
	localparam int CW = $clog2(GRID_DIM * GRID_DIM * GRID_DIM)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    take,
	input  wire pcb_pkg::in_item_t       item,
	input  wire logic [pcb_pkg::POS_W-1:0] cell_size,
	output logic                         busy,
	output logic                         emit,
	input  wire logic                    mid_full,
	output logic [CW-1:0]                cell_no,
	output logic [pcb_pkg::ID_W-1:0]     id
);

	localparam int AW = $clog2(GRID_DIM);
	localparam int SW = $clog2(AW + 1);
	localparam int DW = pcb_pkg::POS_W + AW;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]                  state_q;
	logic [SW-1:0]               step_q;
	logic [pcb_pkg::ID_W-1:0]    id_q;
	logic [DW-1:0]               dsh_q;
	logic [pcb_pkg::POS_W-1:0]   rem_q [3];
	logic [AW-1:0]               quo_q [3];
	logic [2:0]                  ovf_q;

	logic [2:0]                  ge;
	logic [pcb_pkg::POS_W-1:0]   diff [3];
	logic [AW:0]                 quo_nx [3];
	logic [AW-1:0]               axis [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ge[i]     = ({{AW{1'b0}}, rem_q[i]} >= dsh_q);
			diff[i]   = rem_q[i] - dsh_q[pcb_pkg::POS_W-1:0];
			quo_nx[i] = {quo_q[i], ge[i]};
			// A quotient that overflowed or lies past the last cell wraps to cell zero.
			if (ovf_q[i] || (quo_q[i] > AW'(GRID_DIM - 1))) begin
				axis[i] = '0;
			end else begin
				axis[i] = quo_q[i];
			end
		end
	end

	assign cell_no = CW'(axis[0]) * CW'(GRID_DIM * GRID_DIM) + CW'(axis[1]) * CW'(GRID_DIM)
		+ CW'(axis[2]);
	assign id   = id_q;
	assign busy = (state_q != ST_IDLE);
	assign emit = (state_q == ST_EMIT);

	// Restoring division, one quotient bit per cycle. The first step only checks whether
	// the quotient reaches 2**AW, which already means the index wraps.
	always_ff @(posedge clk) begin
		if (take && (state_q == ST_IDLE)) begin
			id_q     <= item.particle_id;
			dsh_q    <= {cell_size, {AW{1'b0}}};
			rem_q[0] <= item.pos_x;
			rem_q[1] <= item.pos_y;
			rem_q[2] <= item.pos_z;
			ovf_q    <= '0;
			for (int i = 0; i < 3; i++) begin
				quo_q[i] <= '0;
			end
		end else if (state_q == ST_DIV) begin
			dsh_q <= dsh_q >> 1;
			for (int i = 0; i < 3; i++) begin
				if (step_q == SW'(AW)) begin
					ovf_q[i] <= ge[i];
				end else begin
					quo_q[i] <= quo_nx[i][AW-1:0];
					if (ge[i]) begin
						rem_q[i] <= diff[i];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_DIV;
						step_q  <= SW'(AW);
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_EMIT;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				ST_EMIT: begin
					if (!mid_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/pcb_back.sv
// Back end: appends a binned particle to its cell list in the head, tail and link stores.
`default_nettype none

module pcb_back #(
	parameter int GRID_DIM      = pcb_pkg::GRID_DIM_DEF,
	parameter int MAX_PARTICLES = pcb_pkg::MAX_PART_DEF,
	localparam int CW = $clog2(GRID_DIM * GRID_DIM * GRID_DIM)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	output logic                          clearing,
	input  wire logic                     mid_empty,
	output logic                          mid_pop,
	input  wire logic [CW-1:0]            mid_cell,
	input  wire logic [pcb_pkg::ID_W-1:0] mid_id,
	input  wire logic                     out_full,
	output logic                          out_push,
	output pcb_pkg::out_item_t            result
);

	localparam int CELL_COUNT = GRID_DIM * GRID_DIM * GRID_DIM;
	localparam int PW         = $clog2(MAX_PARTICLES);
	localparam int IW         = pcb_pkg::ID_W;

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_UPDATE = 2'd2;
	localparam logic [1:0] ST_UNLINK = 2'd3;

	logic [1:0]    state_q;
	logic [CW-1:0] clr_q;
	logic [CW-1:0] cell_q;
	logic [IW-1:0] id_q;

	// Tail store entries carry the occupied flag on top of the tail id.
	logic [IW:0]   tail_mem [CELL_COUNT];
	logic [IW-1:0] head_mem [CELL_COUNT];
	logic [IW-1:0] next_link_mem [MAX_PARTICLES];
	logic          next_present_mem [MAX_PARTICLES];
	logic [IW:0]   tail_rd_q;

	logic            occ;
	logic [IW-1:0]   prev;
	logic [PW+IW-1:0] prev_wide;
	logic [PW+IW-1:0] id_wide;
	logic            prev_ok;
	logic            id_ok;
	logic [CW+IW-1:0] cell_wide;

	logic            tail_we;
	logic [CW-1:0]   tail_waddr;
	logic [IW:0]     tail_wdata;
	logic            link_we;
	logic            pres_we;
	logic [PW-1:0]   pres_addr;
	logic            pres_wdata;

	assign occ       = tail_rd_q[IW];
	assign prev      = tail_rd_q[IW-1:0];
	assign prev_wide = {{PW{1'b0}}, prev};
	assign id_wide   = {{PW{1'b0}}, id_q};
	assign prev_ok   = (prev_wide < (PW + IW)'(MAX_PARTICLES));
	assign id_ok     = (id_wide < (PW + IW)'(MAX_PARTICLES));
	assign cell_wide = {{IW{1'b0}}, cell_q};

	assign clearing = (state_q == ST_CLEAR);
	assign mid_pop  = (state_q == ST_IDLE) && !mid_empty && !out_full;
	assign out_push = (state_q == ST_UPDATE);

	assign result.cell_index   = cell_wide[pcb_pkg::CELL_W-1:0];
	assign result.was_empty    = !occ;
	assign result.linked_after = occ ? prev : '0;

	assign tail_we    = clearing || (state_q == ST_UPDATE);
	assign tail_waddr = clearing ? clr_q : cell_q;
	assign tail_wdata = clearing ? '0 : {1'b1, id_q};

	assign link_we    = (state_q == ST_UPDATE) && occ && prev_ok;

	// The old tail gets its forward link first; the new particle's link is marked
	// absent in the next cycle, so that wins when both name the same id.
	always_comb begin
		if (state_q == ST_UNLINK) begin
			pres_we    = id_ok;
			pres_addr  = id_wide[PW-1:0];
			pres_wdata = 1'b0;
		end else begin
			pres_we    = link_we;
			pres_addr  = prev_wide[PW-1:0];
			pres_wdata = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (tail_we) begin
			tail_mem[tail_waddr] <= tail_wdata;
		end
		if (mid_pop) begin
			tail_rd_q <= tail_mem[mid_cell];
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_UPDATE) && !occ) begin
			head_mem[cell_q] <= id_q;
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			next_link_mem[prev_wide[PW-1:0]] <= id_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pres_we) begin
			next_present_mem[pres_addr] <= pres_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mid_pop) begin
			cell_q <= mid_cell;
			id_q   <= mid_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CW'(CELL_COUNT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (mid_pop) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_UNLINK;
				end
				ST_UNLINK: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/particle_cell_list_binning.sv
// An accepted item is divided in the front end, queued, appended to its cell list in the back
// end and queued again for the ports; only a full queue on the way holds it back.
// The input rate is set by the bit-serial coordinate divider in the front end, which takes one
// item at a time; the list update behind it runs through its update and unlink states.
// After reset the cell store is swept clear, cell by cell;
// full stays high during the sweep, while configuration writes are still taken.
// Reset sets cell_size to 268435456 and empties both queues.
`default_nettype none

module particle_cell_list_binning #(
	parameter int GRID_DIM      = pcb_pkg::GRID_DIM_DEF,
	parameter int MAX_PARTICLES = pcb_pkg::MAX_PART_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [pcb_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [pcb_pkg::DATA_W-1:0]     pwdata,
	output logic      [pcb_pkg::DATA_W-1:0]     prdata,
	output logic                                pready,
	input  wire logic                           push,
	output logic                                full,
	input  wire pcb_pkg::in_item_t              item,
	output logic                                empty,
	input  wire logic                           pop,
	output pcb_pkg::out_item_t                  result
);

	localparam int CW    = $clog2(GRID_DIM * GRID_DIM * GRID_DIM);
	localparam int MID_W = CW + pcb_pkg::ID_W;
	localparam int OUT_W = $bits(pcb_pkg::out_item_t);

	logic [pcb_pkg::POS_W-1:0] cell_size_q;
	logic                      cfg_wr;

	logic                      front_busy;
	logic                      front_emit;
	logic [CW-1:0]             front_cell;
	logic [pcb_pkg::ID_W-1:0]  front_id;
	logic                      take;

	logic                      mid_full;
	logic                      mid_empty;
	logic                      mid_pop;
	logic [MID_W-1:0]          mid_dout;

	logic                      clearing;
	logic                      out_full;
	logic                      out_push;
	pcb_pkg::out_item_t        back_result;
	logic [OUT_W-1:0]          out_dout;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr == pcb_pkg::ADDR_CELL_SIZE) ? cell_size_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q <= pcb_pkg::CELL_SIZE_RST;
		end else if (cfg_wr && (paddr == pcb_pkg::ADDR_CELL_SIZE)) begin
			cell_size_q <= pwdata;
		end
	end

	assign full = front_busy || clearing;
	assign take = push && !full;

	pcb_front #(
		.GRID_DIM (GRID_DIM)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item      (item),
		.cell_size (cell_size_q),
		.busy      (front_busy),
		.emit      (front_emit),
		.mid_full  (mid_full),
		.cell_no   (front_cell),
		.id        (front_id)
	);

	pcb_fifo #(
		.WIDTH (MID_W),
		.DEPTH (pcb_pkg::FIFO_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_emit),
		.din    ({front_cell, front_id}),
		.full   (mid_full),
		.pop    (mid_pop),
		.dout   (mid_dout),
		.empty  (mid_empty)
	);

	pcb_back #(
		.GRID_DIM      (GRID_DIM),
		.MAX_PARTICLES (MAX_PARTICLES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clearing  (clearing),
		.mid_empty (mid_empty),
		.mid_pop   (mid_pop),
		.mid_cell  (mid_dout[MID_W-1:pcb_pkg::ID_W]),
		.mid_id    (mid_dout[pcb_pkg::ID_W-1:0]),
		.out_full  (out_full),
		.out_push  (out_push),
		.result    (back_result)
	);

	pcb_fifo #(
		.WIDTH (OUT_W),
		.DEPTH (pcb_pkg::FIFO_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.din    (back_result),
		.full   (out_full),
		.pop    (pop),
		.dout   (out_dout),
		.empty  (empty)
	);

	assign result = out_dout;

endmodule

`default_nettype wire

### rtl/pcb_checker.sv
// Port-level checks for the binning block, bound to its top level.
`default_nettype none

module pcb_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           psel,
	input wire logic                           penable,
	input wire logic                           pwrite,
	input wire logic [pcb_pkg::APB_ADDR_W-1:0] paddr,
	input wire logic [pcb_pkg::DATA_W-1:0]     pwdata,
	input wire logic [pcb_pkg::DATA_W-1:0]     prdata,
	input wire logic                           pready,
	input wire logic                           push,
	input wire logic                           full,
	input wire logic                           empty,
	input wire logic                           pop,
	input wire pcb_pkg::out_item_t             result
);

	// A waiting result stays put until it is taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed or vanished before its transaction");

	// The divider works on one item at a time, so an accepted item closes the input.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> full)
		else $error("input open right after a transaction");

	// The cell store sweep keeps the input closed as reset lifts.
	a_clear_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> full)
		else $error("input open during the post-reset sweep");

	// A cell size write shows up on the read data in the next cycle.
	a_cfg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && (paddr == pcb_pkg::ADDR_CELL_SIZE)
		|=> (paddr != pcb_pkg::ADDR_CELL_SIZE) || (prdata == $past(pwdata)))
		else $error("cell size readback mismatch");

	// A first entry in a cell has no predecessor.
	a_first_unlinked: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.was_empty |-> (result.linked_after == '0))
		else $error("first entry of a cell reports a predecessor");

endmodule

bind particle_cell_list_binning pcb_checker u_pcb_checker (.*);

`default_nettype wire

### verif/particle_cell_list_binning_test.sv
// Self-checking testbench for the particle cell list binning block.
`timescale 1ns / 100ps

module particle_cell_list_binning_test;

	localparam int ID_W         = pcb_pkg::ID_W;
	localparam int POS_W        = pcb_pkg::POS_W;
	localparam int CELL_W       = pcb_pkg::CELL_W;
	localparam int DATA_W       = pcb_pkg::DATA_W;
	localparam int APB_ADDR_W   = pcb_pkg::APB_ADDR_W;
	localparam int GRID         = pcb_pkg::GRID_DIM_DEF;
	localparam int CELLS        = GRID * GRID * GRID;
	localparam int CELL_BITS    = $clog2(CELLS);
	localparam int PHASES       = 6;
	localparam int RANDOM_EACH  = 270;
	localparam int SETTLE       = 20;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 20000;

	logic      clk;
	logic      arst_n = 1'b0;
	logic      psel = 1'b0;
	logic      penable = 1'b0;
	logic      pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0]     pwdata = '0;
	logic [DATA_W-1:0]     prdata;
	logic      pready;
	logic      push = 1'b0;
	logic      full;
	pcb_pkg::in_item_t  item = '0;
	logic      empty;
	logic      pop = 1'b0;
	pcb_pkg::out_item_t result;

	// Predictor state: configured cell size, cell occupancy and list tails.
	logic [POS_W-1:0] cell_size_model = pcb_pkg::CELL_SIZE_RST;
	bit               cell_busy [CELLS];
	logic [ID_W-1:0]  cell_tail [CELLS];

	pcb_pkg::in_item_t  particles_to_insert [$];
	pcb_pkg::out_item_t expected_bins [$];

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  phase_no = -1;
	logic receiver_hold = 1'b0;
	int  mismatch_count = 0;
	int  quiet_cycles = 0;

	particle_cell_list_binning dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.push    (push),
		.full    (full),
		.item    (item),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	function automatic int unsigned axis_slot(logic [POS_W-1:0] pos);
		logic [POS_W-1:0] q;
		// A zero divisor gives all ones, which then wraps like any other overflow.
		if (cell_size_model == '0) begin
			q = '1;
		end else begin
			q = pos / cell_size_model;
		end
		if (q > GRID - 1) begin
			q = '0;
		end
		return q;
	endfunction

	function automatic pcb_pkg::out_item_t bin_particle(pcb_pkg::in_item_t p);
		pcb_pkg::out_item_t r;
		int unsigned        cell_no;
		cell_no = axis_slot(p.pos_x) * GRID * GRID + axis_slot(p.pos_y) * GRID
			+ axis_slot(p.pos_z);
		if (cell_no >= CELLS) begin
			cell_no = 0;
		end
		r.cell_index = CELL_W'(cell_no);
		if (!cell_busy[cell_no[CELL_BITS-1:0]]) begin
			r.was_empty = 1'b1;
			r.linked_after = '0;
			cell_busy[cell_no[CELL_BITS-1:0]] = 1'b1;
		end else begin
			r.was_empty = 1'b0;
			r.linked_after = cell_tail[cell_no[CELL_BITS-1:0]];
		end
		cell_tail[cell_no[CELL_BITS-1:0]] = p.particle_id;
		return r;
	endfunction

	// Position inside cell idx along one axis, clipped to the coordinate range.
	function automatic logic [POS_W-1:0] at_cell(int unsigned idx, logic [POS_W-1:0] cs,
			logic [POS_W-1:0] offset);
		logic [63:0] pos;
		pos = 64'(idx) * 64'(cs) + 64'(offset);
		if (pos > 64'hFFFF_FFFF) begin
			pos = 64'hFFFF_FFFF;
		end
		return pos[POS_W-1:0];
	endfunction

	function automatic logic [POS_W-1:0] random_coord(logic [POS_W-1:0] cs);
		int unsigned sel;
		int unsigned idx;
		sel = $urandom_range(99);
		if (cs == '0 || sel < 15) begin
			return $urandom;
		end
		if (sel < 22) begin
			return $urandom_range(1) ? '1 : '0;
		end
		// Most coordinates fall in a few low cells so that lists grow long.
		idx = (sel < 85) ? $urandom_range(3) : $urandom_range(GRID + 1);
		return at_cell(idx, cs, $urandom % cs);
	endfunction

	function automatic pcb_pkg::in_item_t make_particle(logic [ID_W-1:0] id,
			logic [POS_W-1:0] x, logic [POS_W-1:0] y, logic [POS_W-1:0] z);
		pcb_pkg::in_item_t p;
		p.particle_id = id;
		p.pos_x = x;
		p.pos_y = y;
		p.pos_z = z;
		return p;
	endfunction

	// Corners, repeated ids, the last cell of each axis and the first index past it.
	task automatic queue_directed(logic [POS_W-1:0] cs);
		logic [POS_W-1:0] last_pos;
		logic [POS_W-1:0] past_pos;
		last_pos = at_cell(GRID - 1, cs, (cs == '0) ? '0 : cs - 1);
		past_pos = at_cell(GRID, cs, '0);
		particles_to_insert.push_back(make_particle('0, '0, '0, '0));
		particles_to_insert.push_back(make_particle('1, '0, '0, '0));
		particles_to_insert.push_back(make_particle('1, '0, '0, '0));
		particles_to_insert.push_back(make_particle(12'h555, '1, '1, '1));
		particles_to_insert.push_back(make_particle(12'hAAA, last_pos, last_pos, last_pos));
		particles_to_insert.push_back(make_particle(12'd1, past_pos, past_pos, past_pos));
		particles_to_insert.push_back(make_particle(12'd2, last_pos, '0, past_pos));
		particles_to_insert.push_back(make_particle(12'd3, '1, past_pos, last_pos));
	endtask

	task automatic cfg_write(logic [APB_ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == pcb_pkg::ADDR_CELL_SIZE) begin
			cell_size_model = data;
		end
	endtask

	task automatic cfg_read_check(logic [APB_ADDR_W-1:0] addr);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== cell_size_model) begin
			report_mismatch("cell_size readback", prdata, cell_size_model);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Driver: offers the oldest pending particle and predicts its bin on acceptance.
	always @(posedge clk) begin
		pcb_pkg::in_item_t next_particle;
		bit                offer;
		if (arst_n && push && !full) begin
			expected_bins.push_back(bin_particle(particles_to_insert.pop_front()));
		end
		offer = particles_to_insert.size() != 0 && $urandom_range(99) >= send_idle_pct;
		next_particle = offer ? particles_to_insert[0] : item;
		push <= offer;
		item <= next_particle;
	end

	// Monitor: checks every popped transaction against the oldest prediction.
	always @(posedge clk) begin
		pcb_pkg::out_item_t want;
		if (arst_n && pop && !empty) begin
			if (expected_bins.size() == 0) begin
				report_mismatch("unexpected result cell_index", 32'(result.cell_index), '0);
			end else begin
				want = expected_bins.pop_front();
				if (result.cell_index !== want.cell_index) begin
					report_mismatch("cell_index", 32'(result.cell_index),
						32'(want.cell_index));
				end
				if (result.was_empty !== want.was_empty) begin
					report_mismatch("was_empty", 32'(result.was_empty), 32'(want.was_empty));
				end
				if (result.linked_after !== want.linked_after) begin
					report_mismatch("linked_after", 32'(result.linked_after),
						32'(want.linked_after));
				end
			end
		end
		pop <= !receiver_hold && $urandom_range(99) >= recv_stall_pct;
	end

	// Long receiver hold-off in the last phase, so the block backs up and stalls its input.
	initial begin
		while (phase_no != PHASES - 1 || particles_to_insert.size() > 150) @(posedge clk);
		receiver_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		receiver_hold <= 1'b0;
	end

	// Watchdog: the post-reset sweep and the hold-off are well inside the limit.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [POS_W-1:0] phase_size [PHASES];
		int               phase_send [PHASES];
		int               phase_recv [PHASES];
		phase_size = '{pcb_pkg::CELL_SIZE_RST, 32'd1, 32'hFFFF_FFFF, 32'd0,
			$urandom_range(2, 65535), $urandom_range(32'h0100_0000, 32'h0FFF_FFFF)};
		phase_send = '{0, 52, 0, 7, 0, 0};
		phase_recv = '{0, 0, 52, 7, 52, 0};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < PHASES; p++) begin
			while (particles_to_insert.size() != 0 || expected_bins.size() != 0) @(posedge clk);
			repeat (SETTLE) @(posedge clk);
			cfg_write(pcb_pkg::ADDR_CELL_SIZE, phase_size[p]);
			cfg_read_check(pcb_pkg::ADDR_CELL_SIZE);
			send_idle_pct <= phase_send[p];
			recv_stall_pct <= phase_recv[p];
			if (p == 0 || p == 1 || p == 3) begin
				queue_directed(phase_size[p]);
			end
			repeat (RANDOM_EACH) begin
				particles_to_insert.push_back(make_particle(ID_W'($urandom_range(4095)),
					random_coord(phase_size[p]), random_coord(phase_size[p]),
					random_coord(phase_size[p])));
			end
			phase_no <= p;
		end
		while (particles_to_insert.size() != 0 || expected_bins.size() != 0) @(posedge clk);
		repeat (2 * SETTLE) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
